### sv/dld_pkg.sv
// ----------------------------------------------------------------------------
// dld_pkg
// Types and constants shared by the doorbell latency device.
// ----------------------------------------------------------------------------
package dld_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int QW          = $clog2(QUEUE_DEPTH);
    localparam int FW          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] DEFAULT_LATENCY_RST = 32'd5000;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    localparam logic [3:0] RIDX_STATUS    = 4'd0;
    localparam logic [3:0] RIDX_DONE      = 4'd1;
    localparam logic [3:0] RIDX_TICKET    = 4'd2;
    localparam logic [3:0] RIDX_RESULT    = 4'd3;
    localparam logic [3:0] RIDX_IRQ_ACK   = 4'd4;
    localparam logic [3:0] RIDX_DOORBELL  = 4'd5;
    localparam logic [3:0] RIDX_OVERRIDE  = 4'd6;
    localparam logic [3:0] RIDX_ARG_FIRST = 4'd7;
    localparam logic [3:0] RIDX_ARG_LAST  = 4'd10;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_READ    = 2'd1;
    localparam logic [1:0] KIND_ACK     = 2'd2;
    localparam logic [1:0] KIND_RELEASE = 2'd3;

    localparam logic [1:0] FAULT_NONE    = 2'd0;
    localparam logic [1:0] FAULT_DIR     = 2'd1;
    localparam logic [1:0] FAULT_UNKNOWN = 2'd2;

    localparam logic [1:0] CFG_DEFAULT_LATENCY = 2'd0;
    localparam logic [1:0] CFG_BLOCKING        = 2'd1;
    localparam logic [1:0] CFG_IRQ_ENABLE      = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  reg_index;
        logic [63:0] write_data;
        logic [3:0]  read_bytes;
        logic        posted;
    } req_t;

    typedef struct packed {
        logic [1:0]  resp_kind;
        logic [63:0] read_data;
        logic [1:0]  access_fault;
        logic        doorbell_dropped;
        logic        protocol_error;
        logic        irq_level;
        logic        irq_changed;
        logic        last_result;
    } resp_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [63:0] data;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_DRAIN,
        ST_ACT,
        ST_OUT_REL,
        ST_OUT_MAIN
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic pre;
        logic drain;
        logic act;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_drain;
        logic released;
        logic main_out;
    } stat_t;

endpackage

### sv/dld_if.sv
// ----------------------------------------------------------------------------
// dld_req_if / dld_resp_if / dld_cfg_if
// Valid/ready channels of the doorbell latency device.
// ----------------------------------------------------------------------------
interface dld_req_if;
    logic valid;
    logic ready;
    dld_pkg::req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dld_resp_if;
    logic valid;
    logic ready;
    dld_pkg::resp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dld_cfg_if;
    logic valid;
    logic ready;
    dld_pkg::cfg_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/dld_ctrl.sv
// ----------------------------------------------------------------------------
// dld_ctrl
// Sequencer: retire check, queue drain, access, then one or two responses.
// ----------------------------------------------------------------------------
module dld_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           out_release,
    output dld_pkg::cmd_t  cmd,
    input  dld_pkg::stat_t stat
);
    import dld_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_PRE;
            ST_PRE:   state_next = ST_DRAIN;
            // the retire flag is only valid once the check has been registered
            ST_DRAIN: if (!stat.need_drain) state_next = ST_ACT;
            ST_ACT:   state_next = stat.released ? ST_OUT_REL : ST_OUT_MAIN;
            ST_OUT_REL:
                if (out_ready) state_next = stat.main_out ? ST_OUT_MAIN : ST_IDLE;
            ST_OUT_MAIN: if (out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        out_release = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_PRE:      cmd.pre = 1'b1;
            ST_DRAIN:    cmd.drain = stat.need_drain;
            ST_ACT:      cmd.act = 1'b1;
            ST_OUT_REL:
            begin
                out_valid   = 1'b1;
                out_release = 1'b1;
            end
            ST_OUT_MAIN: out_valid = 1'b1;
            default:     ;
        endcase
    end

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.pre, cmd.drain, cmd.act}))
        else $error("more than one datapath command");
    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request taken while response pending");
    a_act_then_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.act |=> out_valid)
        else $error("access not followed by response");
endmodule

### sv/dld_datapath.sv
// ----------------------------------------------------------------------------
// dld_datapath
// Counters, launch queue, interrupt state and response formation.
// ----------------------------------------------------------------------------
module dld_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  dld_pkg::req_t   req,
    input  logic            cfg_we,
    input  dld_pkg::cfg_t   cfg,
    input  logic            out_release,
    input  dld_pkg::cmd_t   cmd,
    output dld_pkg::stat_t  stat,
    output dld_pkg::resp_t  resp
);
    import dld_pkg::*;

    logic [31:0] dlat_reg;
    logic        block_reg, irqen_reg;
    logic [63:0] cyc_reg, dl_reg, done_reg, tick_reg, evt_reg;
    logic [31:0] ovr_reg;
    logic [FW-1:0] fill_reg;
    logic [QW-1:0] head_reg;
    logic        pend_reg, held_reg, rel_reg, before_reg;
    req_t        req_reg;
    logic [63:0] now_reg;
    logic [1:0]  kind_reg, fault_reg;
    logic [63:0] data_reg;
    logic        drop_reg, perr_reg;
    logic        irq0_reg;
    logic [31:0] queue [QUEUE_DEPTH];

    logic retiring, retire_item;
    logic [63:0] evt_inc;
    logic [QW-1:0] tail;
    logic [31:0] lat;
    logic [63:0] masked;
    logic [63:0] rd;
    logic [1:0]  fl;
    logic        start_now, busy_after, act_hold;
    logic [1:0]  kind_next, fault_next;
    logic [63:0] data_next;
    logic        drop_next, perr_next;

    // retire is only performed by ticks and retiring reads/doorbell writes
    always_comb
    begin
        retire_item = (req_reg.func == FUNC_TICK) ||
                      (req_reg.func == FUNC_READ && (req_reg.reg_index == RIDX_STATUS ||
                        req_reg.reg_index == RIDX_DONE || req_reg.reg_index == RIDX_RESULT)) ||
                      (req_reg.func == FUNC_WRITE && req_reg.reg_index == RIDX_DOORBELL);
        retiring = retire_item && dl_reg != 64'd0 && now_reg >= dl_reg;
        evt_inc  = (evt_reg != '1) ? evt_reg + 64'd1 : evt_reg;
        tail     = QW'((32'(head_reg) + 32'(fill_reg)) % QUEUE_DEPTH);
        lat      = (ovr_reg != 32'd0) ? ovr_reg : dlat_reg;
    end

    assign stat.need_drain = rel_reg && fill_reg != '0 && dl_reg == 64'd0;
    assign stat.released   = rel_reg && held_reg == 1'b0 && before_reg;
    assign stat.main_out   = !(req_reg.func == FUNC_TICK);

    always_ff @(posedge clk)
    begin
        if (cmd.act && req_reg.func == FUNC_WRITE && req_reg.reg_index == RIDX_DOORBELL &&
            !start_now && 32'(fill_reg) < QUEUE_DEPTH)
            queue[tail] <= lat;
    end

    // response fields and hold decision of the access step
    always_comb
    begin
        start_now  = dl_reg == 64'd0 && fill_reg == '0;
        busy_after = start_now ? (lat != 32'd0) : (dl_reg != 64'd0);
        kind_next  = KIND_NONE;
        fault_next = FAULT_NONE;
        data_next  = '0;
        drop_next  = 1'b0;
        perr_next  = 1'b0;
        act_hold   = 1'b0;
        if (req_reg.func == FUNC_READ)
        begin
            kind_next  = KIND_READ;
            data_next  = masked;
            fault_next = fl;
        end
        else if (req_reg.func == FUNC_WRITE)
        begin
            unique case (req_reg.reg_index) inside
                RIDX_DOORBELL:
                begin
                    if (!start_now && 32'(fill_reg) >= QUEUE_DEPTH)
                        drop_next = 1'b1;
                    if (block_reg && !req_reg.posted && busy_after)
                    begin
                        if (held_reg)
                            perr_next = 1'b1;
                        else
                            act_hold = 1'b1;
                    end
                end
                [RIDX_STATUS:RIDX_RESULT]:
                    fault_next = FAULT_DIR;
                RIDX_IRQ_ACK, RIDX_OVERRIDE, [RIDX_ARG_FIRST:RIDX_ARG_LAST]:
                    ;
                default:
                    fault_next = FAULT_UNKNOWN;
            endcase
            if (!req_reg.posted && !act_hold)
                kind_next = KIND_ACK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dlat_reg   <= DEFAULT_LATENCY_RST;
            block_reg  <= 1'b0;
            irqen_reg  <= 1'b0;
            cyc_reg    <= '0;
            dl_reg     <= '0;
            done_reg   <= '0;
            tick_reg   <= '0;
            evt_reg    <= '0;
            ovr_reg    <= '0;
            fill_reg   <= '0;
            head_reg   <= '0;
            pend_reg   <= 1'b0;
            held_reg   <= 1'b0;
            rel_reg    <= 1'b0;
            before_reg <= 1'b0;
            kind_reg   <= KIND_NONE;
            fault_reg  <= FAULT_NONE;
            drop_reg   <= 1'b0;
            perr_reg   <= 1'b0;
            data_reg   <= '0;
            req_reg    <= '0;
            now_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg.index)
                    CFG_DEFAULT_LATENCY: dlat_reg  <= cfg.data[31:0];
                    CFG_BLOCKING:        block_reg <= cfg.data[0];
                    CFG_IRQ_ENABLE:      irqen_reg <= cfg.data[0];
                    default:             ;
                endcase
            end
            if (cmd.load)
            begin
                req_reg    <= req;
                before_reg <= pend_reg;
                if (req.func == FUNC_TICK)
                begin
                    cyc_reg <= cyc_reg + 64'd1;
                    now_reg <= cyc_reg + 64'd1;
                end
                else
                    now_reg <= cyc_reg;
            end
            if (cmd.pre)
            begin
                // before_reg now carries "held ack released" for the item
                before_reg <= retiring && held_reg;
                rel_reg    <= retiring;
                if (retiring)
                begin
                    done_reg <= done_reg + 64'd1;
                    dl_reg   <= '0;
                    held_reg <= 1'b0;
                    if (irqen_reg)
                    begin
                        evt_reg  <= evt_inc;
                        pend_reg <= 1'b1;
                    end
                end
            end
            if (cmd.drain)
            begin
                // pop one queued job; zero latency completes at once
                head_reg <= QW'((32'(head_reg) + 1) % QUEUE_DEPTH);
                fill_reg <= fill_reg - FW'(1);
                if (queue[head_reg] == 32'd0)
                begin
                    done_reg <= done_reg + 64'd1;
                    if (irqen_reg)
                    begin
                        evt_reg  <= evt_inc;
                        pend_reg <= 1'b1;
                    end
                end
                else
                    dl_reg <= now_reg + 64'(queue[head_reg]);
            end
            if (cmd.act)
            begin
                kind_reg  <= kind_next;
                fault_reg <= fault_next;
                drop_reg  <= drop_next;
                perr_reg  <= perr_next;
                data_reg  <= data_next;
                if (act_hold)
                    held_reg <= 1'b1;
                if (req_reg.func == FUNC_WRITE)
                begin
                    unique case (req_reg.reg_index)
                        RIDX_DOORBELL:
                        begin
                            ovr_reg <= '0;
                            if (start_now)
                            begin
                                tick_reg <= tick_reg + 64'd1;
                                if (lat == 32'd0)
                                begin
                                    done_reg <= done_reg + 64'd1;
                                    if (irqen_reg)
                                    begin
                                        evt_reg  <= evt_inc;
                                        pend_reg <= 1'b1;
                                    end
                                end
                                else
                                    dl_reg <= now_reg + 64'(lat);
                            end
                            else if (32'(fill_reg) < QUEUE_DEPTH)
                            begin
                                tick_reg <= tick_reg + 64'd1;
                                fill_reg <= fill_reg + FW'(1);
                            end
                        end
                        RIDX_OVERRIDE: ovr_reg <= req_reg.write_data[31:0];
                        RIDX_IRQ_ACK:
                        begin
                            if (req_reg.write_data != 64'd0 && irqen_reg && pend_reg)
                            begin
                                if (req_reg.write_data < evt_reg)
                                    evt_reg <= evt_reg - req_reg.write_data;
                                else
                                begin
                                    evt_reg  <= '0;
                                    pend_reg <= 1'b0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_comb
    begin
        rd = '0;
        fl = FAULT_NONE;
        unique case (req_reg.reg_index) inside
            RIDX_STATUS:                  rd = {63'd0, dl_reg != 64'd0};
            RIDX_DONE, RIDX_RESULT:       rd = done_reg;
            RIDX_TICKET:                  rd = tick_reg;
            RIDX_IRQ_ACK:                 rd = {63'd0, pend_reg};
            RIDX_DOORBELL, RIDX_OVERRIDE: fl = FAULT_DIR;
            default:                      fl = FAULT_UNKNOWN;
        endcase
        masked = rd;
        if (req_reg.read_bytes == 4'd0)
            masked = '0;
        else if (req_reg.read_bytes < 4'd8)
            masked = rd & ((64'd1 << {req_reg.read_bytes[2:0], 3'b000}) - 64'd1);
    end

    always_comb
    begin
        resp.irq_level   = pend_reg;
        resp.irq_changed = pend_reg != irq0_reg;
        if (out_release)
        begin
            resp.resp_kind        = KIND_RELEASE;
            resp.read_data        = '0;
            resp.access_fault     = FAULT_NONE;
            resp.doorbell_dropped = 1'b0;
            resp.protocol_error   = 1'b0;
            resp.last_result      = req_reg.func == FUNC_TICK;
        end
        else
        begin
            resp.resp_kind        = kind_reg;
            resp.read_data        = data_reg;
            resp.access_fault     = fault_reg;
            resp.doorbell_dropped = drop_reg;
            resp.protocol_error   = perr_reg;
            resp.last_result      = 1'b1;
        end
    end

    // irq level at start of the item, kept apart from the release flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            irq0_reg <= 1'b0;
        else if (cmd.load)
            irq0_reg <= pend_reg;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= QUEUE_DEPTH)
        else $error("queue overfilled");
    a_drain_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drain |-> dl_reg == 64'd0 && fill_reg != '0)
        else $error("drain while busy or empty");
    a_evt_pend: assert property (@(posedge clk) disable iff (!rst_n)
        evt_reg != 64'd0 |-> pend_reg)
        else $error("events counted with line low");
endmodule

### sv/doorbell_latency_device.sv
// ----------------------------------------------------------------------------
// doorbell_latency_device
// Register-mapped job launcher with a modelled busy window and launch queue.
// ----------------------------------------------------------------------------
// channel  direction  payload
// req      in         func, reg_index, write_data, read_bytes, posted
// resp     out        resp_kind .. last_result, one or two per request
// cfg      in         register index, write data
//
// A request passes accept, retire check, drain check and access, then its
// response beats; after a retire, queued jobs drain until one starts or
// the queue empties. The sequencer handles one request at a time.
// Reset restores all counters and registers; the queue store is not cleared.
// A stalled response holds the sequencer; cfg writes are always accepted.
// ----------------------------------------------------------------------------
module doorbell_latency_device (
    input logic clk,
    input logic rst_n,
    dld_req_if.sink    req,
    dld_resp_if.source resp,
    dld_cfg_if.sink    cfg
);
    import dld_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  out_release;

    assign cfg.ready = 1'b1;

    dld_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_ready    (req.ready),
        .out_valid   (resp.valid),
        .out_ready   (resp.ready),
        .out_release (out_release),
        .cmd         (cmd),
        .stat        (stat)
    );

    dld_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req.data),
        .cfg_we      (cfg.valid),
        .cfg         (cfg.data),
        .out_release (out_release),
        .cmd         (cmd),
        .stat        (stat),
        .resp        (resp.data)
    );
endmodule
